// ===== hw/rtl/ppb_pkg.sv =====
// ----------------------------------------------------------------------------
// ppb_pkg
// Shared types and constants for the ping-pong double buffer.
// ----------------------------------------------------------------------------
package ppb_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned MAX_DEPTH_DEF  = 256;

  localparam logic [3:0] DEPTH_LOG2_RESET = 4'd8;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    op_t         opcode;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] read_data;
    logic [8:0]  readable_count;
    logic        read_side_empty;
    logic        write_side_full;
    logic        swapped;
  } out_item_t;

  // bank depth for a log2 setting, saturated at the largest power of two
  // that fits the physical bank
  function automatic int unsigned depth_from_log2(input logic [3:0] lg,
                                                  input int unsigned max_log);
    int unsigned d;
    if (int'(lg) > int'(max_log)) begin
      d = 32'd1 << max_log;
    end else begin
      d = 32'd1 << lg;
    end
    return d;
  endfunction

endpackage

// ===== hw/rtl/ping_pong_buffer_swap_on_full.sv =====
// ----------------------------------------------------------------------------
// ping_pong_buffer_swap_on_full
// Two-bank ping-pong buffer; banks swap roles when the write bank fills
// while the read bank is drained.
// ----------------------------------------------------------------------------
// Pipeline: results pass through the bank read stage, then the output
//   register.
// Throughput: one item per cycle while in_stall is low; bank storage has one write and one read port.
// Stalls: a stalled result holds the output; one more item enters the read
//   stage, then in_stall rises until the output is taken.
// Reset: synchronous; depth_log2 = 8, bank zero in write role, read side
//   empty. Bank contents are not cleared.
module ping_pong_buffer_swap_on_full #(
  parameter int unsigned DATA_WIDTH = ppb_pkg::DATA_WIDTH_DEF,
  parameter int unsigned MAX_DEPTH  = ppb_pkg::MAX_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  ppb_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output ppb_pkg::out_item_t out_item
);

  localparam int unsigned PW      = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned MAX_LOG = $clog2(MAX_DEPTH + 1) - 1;

  logic [PW-1:0] depth_r, wr_pos_r, rd_pos_r;
  logic          wr_sel_r;
  logic [PW-1:0] depth_nxt, wr_pos_nxt, rd_pos_nxt;
  logic          wr_sel_nxt;
  logic [PW-1:0] cfg_depth, rst_depth;

  logic               s1_valid_r, s1_rd_r;
  ppb_pkg::out_item_t s1_item_r, s1_item_nxt;
  logic               out_valid_r;
  ppb_pkg::out_item_t out_item_r, out_item_nxt;

  logic s1_hold, s1_load, accept;
  logic rd_empty, wr_full, pre_swap, post_swap, refused;
  logic          sel1;
  logic [PW-1:0] wp1, rp1, wp2;

  logic                  mem_we, mem_re;
  logic [AW:0]           mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  assign cfg_depth = PW'(ppb_pkg::depth_from_log2(cfg_wdata, MAX_LOG));
  assign rst_depth = PW'(ppb_pkg::depth_from_log2(ppb_pkg::DEPTH_LOG2_RESET, MAX_LOG));

  assign s1_hold  = out_valid_r & out_stall;
  assign s1_load  = ~s1_hold | ~s1_valid_r;
  assign in_stall = s1_valid_r & s1_hold;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    rd_empty  = (rd_pos_r >= depth_r);
    wr_full   = (wr_pos_r >= depth_r);
    pre_swap  = wr_full & rd_empty;
    refused   = wr_full & ~rd_empty;
    sel1      = wr_sel_r ^ pre_swap;
    wp1       = pre_swap ? '0 : wr_pos_r;
    rp1       = pre_swap ? '0 : rd_pos_r;
    wp2       = wp1 + PW'(1);
    post_swap = (wp2 == depth_r) && (rp1 >= depth_r);

    depth_nxt  = depth_r;
    wr_sel_nxt = wr_sel_r;
    wr_pos_nxt = wr_pos_r;
    rd_pos_nxt = rd_pos_r;

    mem_we    = 1'b0;
    mem_waddr = {sel1, wp1[AW-1:0]};
    mem_wdata = DATA_WIDTH'(in_item.write_data);
    mem_re    = 1'b0;
    mem_raddr = {~wr_sel_r, rd_pos_r[AW-1:0]};

    s1_item_nxt         = '0;
    s1_item_nxt.status  = ppb_pkg::STATUS_OK;

    if (cfg_we) begin
      depth_nxt  = cfg_depth;
      wr_sel_nxt = 1'b0;
      wr_pos_nxt = '0;
      rd_pos_nxt = cfg_depth;
    end else if (accept) begin
      unique case (in_item.opcode)
        ppb_pkg::OP_WRITE: begin
          if (refused) begin
            s1_item_nxt.status = ppb_pkg::STATUS_FULL;
          end else begin
            mem_we = 1'b1;
            if (post_swap) begin
              wr_sel_nxt = ~sel1;
              wr_pos_nxt = '0;
              rd_pos_nxt = '0;
            end else begin
              wr_sel_nxt = sel1;
              wr_pos_nxt = wp2;
              rd_pos_nxt = rp1;
            end
          end
          s1_item_nxt.swapped = pre_swap | (~refused & post_swap);
        end
        ppb_pkg::OP_READ: begin
          if (rd_empty) begin
            s1_item_nxt.status = ppb_pkg::STATUS_EMPTY;
          end else begin
            mem_re     = 1'b1;
            rd_pos_nxt = rd_pos_r + PW'(1);
          end
        end
        default: ;
      endcase
    end

    s1_item_nxt.read_side_empty = (rd_pos_nxt >= depth_r);
    s1_item_nxt.write_side_full = (wr_pos_nxt >= depth_r);
    s1_item_nxt.readable_count  = s1_item_nxt.read_side_empty ? '0 :
                                  9'(depth_r - rd_pos_nxt);
  end

  ppb_bank_mem #(
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_WIDTH (AW + 1)
  ) u_bank_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= rst_depth;
      wr_sel_r <= 1'b0;
      wr_pos_r <= '0;
      rd_pos_r <= rst_depth;
    end else begin
      depth_r  <= depth_nxt;
      wr_sel_r <= wr_sel_nxt;
      wr_pos_r <= wr_pos_nxt;
      rd_pos_r <= rd_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= accept;
      end
      if (!s1_hold) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_comb begin
    out_item_nxt = s1_item_r;
    if (s1_rd_r) begin
      out_item_nxt.read_data = 32'(mem_rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item_r <= s1_item_nxt;
      s1_rd_r   <= mem_re;
    end
    if (!s1_hold) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_pos_r <= depth_r) && (rd_pos_r <= depth_r))
    else $error("bank position beyond configured depth");

  a_refused_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.status != ppb_pkg::STATUS_OK) |-> out_item_r.read_data == '0)
    else $error("refused item carries read data");

  a_swap_state: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_item_r.swapped |-> !s1_item_r.read_side_empty)
    else $error("swap left read side empty");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_hold |=> s1_valid_r && $stable(s1_item_r) && $stable(s1_rd_r))
    else $error("read stage changed while held");

endmodule

// ===== hw/rtl/ppb_bank_mem.sv =====
// ----------------------------------------------------------------------------
// ppb_bank_mem
// Simple dual-port bank storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ppb_bank_mem #(
  parameter int unsigned DATA_WIDTH = ppb_pkg::DATA_WIDTH_DEF,
  parameter int unsigned ADDR_WIDTH = 9
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [ADDR_WIDTH-1:0] wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [ADDR_WIDTH-1:0] rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data
);

  localparam int unsigned ENTRIES = 2 ** ADDR_WIDTH;

  logic [DATA_WIDTH-1:0] mem [ENTRIES];
  logic [DATA_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== dv/ping_pong_buffer_swap_on_full_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ping_pong_buffer_swap_on_full_tb
// Self-checking bench for the two-bank ping-pong buffer. A short table of
// directed items covers bank swaps, refused writes and reads, and depth
// saturation. Random phases follow at several depths, from one word up to
// the full 256. Each result is compared with an in-bench bank model or, for
// typed rows, their table entry, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module ping_pong_buffer_swap_on_full_tb;
  import ppb_pkg::*;

  typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_TYPED} row_kind_t;
  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  typedef struct {
    row_kind_t   kind;
    logic [3:0]  cfg;
    op_t         op;
    logic [31:0] data;
    out_item_t   want;
  } dir_row_t;

  localparam out_item_t NO_RESULT = '0;
  localparam int DIR_N = 25;
  localparam int PH_N  = 10;
  localparam logic [3:0] PH_DEPTH [PH_N] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd15,
                                             4'd4, 4'd5, 4'd2, 4'd1, 4'd0};
  localparam int PH_ITEMS  [PH_N] = '{80, 100, 150, 150, 540, 150, 200, 120, 80, 55};
  localparam int PH_WR_PCT [PH_N] = '{50, 55, 60, 50, 70, 55, 60, 40, 65, 50};

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [3:0] cfg_wdata = '0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;

  // buffer model state
  logic [31:0] bank_mem [2][256];
  logic        wr_bank   = 1'b0;
  int          wr_ptr    = 0;
  int          buf_depth = 1 << DEPTH_LOG2_RESET;
  int          rd_ptr    = 1 << DEPTH_LOG2_RESET;

  out_item_t pending_results [$];
  dir_row_t  dir_rows [DIR_N];

  int mismatch_count = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int swap_count     = 0;
  int full_refusals  = 0;
  int empty_refusals = 0;
  int depth_settings = 0;
  int burst_left     = 0;
  int stall_tick     = 0;
  rx_mode_t stall_mode = RX_FREE;

  ping_pong_buffer_swap_on_full i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void flip_banks();
    wr_bank = ~wr_bank;
    wr_ptr  = 0;
    rd_ptr  = 0;
  endfunction

  function automatic out_item_t buffer_outcome(input in_item_t it);
    out_item_t r;
    logic      ok;
    r = '0;
    r.status = STATUS_OK;
    if (it.opcode == OP_WRITE) begin
      ok = 1'b1;
      if (wr_ptr >= buf_depth) begin
        if (rd_ptr >= buf_depth) begin
          flip_banks();
          r.swapped = 1'b1;
        end else begin
          ok = 1'b0;
          r.status = STATUS_FULL;
        end
      end
      if (ok) begin
        bank_mem[wr_bank][wr_ptr] = it.write_data;
        wr_ptr++;
        if (wr_ptr == buf_depth && rd_ptr >= buf_depth) begin
          flip_banks();
          r.swapped = 1'b1;
        end
      end
    end else begin
      if (rd_ptr >= buf_depth) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.read_data = bank_mem[~wr_bank][rd_ptr];
        rd_ptr++;
      end
    end
    r.readable_count  = (rd_ptr >= buf_depth) ? 9'd0 : 9'(buf_depth - rd_ptr);
    r.read_side_empty = (rd_ptr >= buf_depth);
    r.write_side_full = (wr_ptr >= buf_depth);
    swap_count     += r.swapped;
    full_refusals  += (r.status == STATUS_FULL);
    empty_refusals += (r.status == STATUS_EMPTY);
    return r;
  endfunction

  // drive one item, hold it until accepted, then log its expected result
  task automatic push_item(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t r;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    r = buffer_outcome(it);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(7) == 0) ? 60 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_depth(input logic [3:0] lg);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= lg;
    @(posedge clk);
    cfg_we    <= 1'b0;
    buf_depth = (lg > 4'd8) ? 256 : (1 << lg);
    wr_bank   = 1'b0;
    wr_ptr    = 0;
    rd_ptr    = buf_depth;
    depth_settings++;
  endtask

  // receiver stall pattern, switching at random between free, light, periodic and heavy modes
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 40 == 0) stall_mode = rx_mode_t'($urandom_range(3));
    case (stall_mode)
      RX_FREE:     out_stall <= 1'b0;
      RX_LIGHT:    out_stall <= ($urandom_range(9) < 3);
      RX_PERIODIC: out_stall <= (stall_tick % 3 == 0);
      default:     out_stall <= ($urandom_range(9) < 7);
    endcase
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result %p", $realtime, out_item);
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status || out_item.read_data !== want.read_data ||
            out_item.readable_count !== want.readable_count ||
            out_item.read_side_empty !== want.read_side_empty ||
            out_item.write_side_full !== want.write_side_full ||
            out_item.swapped !== want.swapped) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result %0d expected %p got %p",
                     $realtime, results_seen, want, out_item);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    in_item_t it;
    int       p;
    int       k;
    dir_rows = '{
      '{ROW_TYPED, 4'd0,  OP_READ,  32'h0,
        '{STATUS_EMPTY, 32'h0, 9'd0, 1'b1, 1'b0, 1'b0}},
      '{ROW_ITEM,  4'd0,  OP_WRITE, 32'hFFFF_FFFF, NO_RESULT},
      '{ROW_ITEM,  4'd0,  OP_WRITE, 32'h0000_0000, NO_RESULT},
      '{ROW_CFG,   4'd0,  OP_WRITE, 32'h0,         NO_RESULT},
      '{ROW_ITEM,  4'd0,  OP_WRITE, 32'h0000_0000, NO_RESULT},
      '{ROW_ITEM,  4'd0,  OP_WRITE, 32'hFFFF_FFFF, NO_RESULT},
      '{ROW_TYPED, 4'd0,  OP_WRITE, 32'h1234_5678,
        '{STATUS_FULL, 32'h0, 9'd1, 1'b0, 1'b1, 1'b0}},
      '{ROW_ITEM,  4'd0,  OP_READ,  32'h0,         NO_RESULT},
      '{ROW_TYPED, 4'd0,  OP_READ,  32'h0,
        '{STATUS_EMPTY, 32'h0, 9'd0, 1'b1, 1'b1, 1'b0}},
      '{ROW_ITEM,  4'd0,  OP_WRITE, 32'h5A5A_5A5A, NO_RESULT},
      '{ROW_ITEM,  4'd0,  OP_READ,  32'h0,         NO_RESULT},
      '{ROW_CFG,   4'd15, OP_WRITE, 32'h0,         NO_RESULT},
      '{ROW_TYPED, 4'd0,  OP_READ,  32'h0,
        '{STATUS_EMPTY, 32'h0, 9'd0, 1'b1, 1'b0, 1'b0}},
      '{ROW_TYPED, 4'd0,  OP_WRITE, 32'h8000_0001,
        '{STATUS_OK, 32'h0, 9'd0, 1'b1, 1'b0, 1'b0}},
      '{ROW_CFG,   4'd1,  OP_WRITE, 32'h0,         NO_RESULT},
      '{ROW_ITEM,  4'd0,  OP_WRITE, 32'h7FFF_FFFE, NO_RESULT},
      '{ROW_ITEM,  4'd0,  OP_WRITE, 32'hFFFF_FFFF, NO_RESULT},
      '{ROW_ITEM,  4'd0,  OP_WRITE, 32'h0000_0001, NO_RESULT},
      '{ROW_ITEM,  4'd0,  OP_READ,  32'hFFFF_FFFF, NO_RESULT},
      '{ROW_ITEM,  4'd0,  OP_WRITE, 32'h0F0F_0F0F, NO_RESULT},
      '{ROW_ITEM,  4'd0,  OP_WRITE, 32'hF0F0_F0F0, NO_RESULT},
      '{ROW_ITEM,  4'd0,  OP_READ,  32'h0,         NO_RESULT},
      '{ROW_ITEM,  4'd0,  OP_WRITE, 32'hDEAD_BEEF, NO_RESULT},
      '{ROW_ITEM,  4'd0,  OP_READ,  32'h0,         NO_RESULT},
      '{ROW_ITEM,  4'd0,  OP_READ,  32'h0,         NO_RESULT}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < DIR_N; k++) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        set_depth(dir_rows[k].cfg);
      end else begin
        pace();
        it.opcode     = dir_rows[k].op;
        it.write_data = dir_rows[k].data;
        push_item(it, dir_rows[k].kind == ROW_TYPED, dir_rows[k].want);
      end
    end

    for (p = 0; p < PH_N; p++) begin
      set_depth(PH_DEPTH[p]);
      for (k = 0; k < PH_ITEMS[p]; k++) begin
        pace();
        if (p % 3 == 1 && k == PH_ITEMS[p] / 2) wait_drained();
        it.opcode = ($urandom_range(99) < PH_WR_PCT[p]) ? OP_WRITE : OP_READ;
        case ($urandom_range(7))
          0:       it.write_data = 32'h0;
          1:       it.write_data = 32'hFFFF_FFFF;
          default: it.write_data = $urandom;
        endcase
        push_item(it, 1'b0, NO_RESULT);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Covered %0d items, %0d results over %0d depth settings (1 to 256 words).",
             items_sent, results_seen, depth_settings);
    $display("Bank swaps %0d, refused writes %0d, refused reads %0d, mismatches %0d.",
             swap_count, full_refusals, empty_refusals, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
